[hdl/bcdd_pkg.sv]
// Shared constants for the BCD digit display driver.
package bcdd_pkg;

    localparam int VALUE_W            = 32;
    localparam int DIGIT_W            = 4;
    localparam int CNT_W              = 4;
    localparam int POS_W              = 4;
    localparam int MAX_DIGITS_DEFAULT = 10;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [CNT_W-1:0]   DIGIT_COUNT_RESET = 4'd3;

    // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
    localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

endpackage

[hdl/bcdd_queue.sv]
// Two-entry queue between the conversion front and the digit emitter.
module bcdd_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             head_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = (bcdd_pkg::QUEUE_DEPTH > 1) ? $clog2(bcdd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(bcdd_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(bcdd_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(bcdd_pkg::QUEUE_DEPTH - 1);

    logic [WIDTH-1:0]  mem_reg [bcdd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/bcdd_front.sv]
// Front end: accepts a value, splits it into decimal digits and classifies overflow.
module bcdd_front #(
    parameter int MAX_DIGITS = bcdd_pkg::MAX_DIGITS_DEFAULT
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic [bcdd_pkg::VALUE_W-1:0]                s_value,
    input  logic [bcdd_pkg::CNT_W-1:0]                  digit_count,
    output logic                                        push_valid,
    input  logic                                        push_ready,
    output logic [MAX_DIGITS*bcdd_pkg::DIGIT_W+bcdd_pkg::CNT_W:0] push_data
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [bcdd_pkg::CNT_W-1:0] MAX_CNT = bcdd_pkg::CNT_W'(MAX_DIGITS);

    logic                                   busy_reg, busy_next;
    logic [bcdd_pkg::VALUE_W-1:0]           rest_reg, rest_next;
    logic [bcdd_pkg::CNT_W-1:0]             n_reg, n_next;
    logic [bcdd_pkg::CNT_W-1:0]             k_reg, k_next;
    logic [MAX_DIGITS-1:0][bcdd_pkg::DIGIT_W-1:0] digits_reg;

    logic [2*bcdd_pkg::VALUE_W-1:0] prod;
    logic [bcdd_pkg::VALUE_W-1:0]   quot, quot_x10, rem_full;
    logic [bcdd_pkg::DIGIT_W-1:0]   rem_digit;
    logic over_max, done, err, push, finish, accept, step;

    // one digit per cycle: quotient by reciprocal multiply, remainder by shift-add
    assign prod      = {{bcdd_pkg::VALUE_W{1'b0}}, rest_reg}
                     * {{bcdd_pkg::VALUE_W{1'b0}}, bcdd_pkg::RECIP_10};
    assign quot      = bcdd_pkg::VALUE_W'(prod >> bcdd_pkg::RECIP_SHIFT);
    assign quot_x10  = {quot[bcdd_pkg::VALUE_W-4:0], 3'b000}
                     + {quot[bcdd_pkg::VALUE_W-2:0], 1'b0};
    assign rem_full  = rest_reg - quot_x10;
    assign rem_digit = rem_full[bcdd_pkg::DIGIT_W-1:0];

    assign over_max = (n_reg > MAX_CNT);
    assign done     = busy_reg && (over_max || (k_reg == n_reg));
    assign err      = over_max || (rest_reg != '0);
    // an empty display with a zero value yields nothing: drop it
    assign push     = done && (err || (n_reg != '0));
    assign finish   = done && (!push || push_ready);
    assign s_ready  = !busy_reg || finish;
    assign accept   = s_valid && s_ready;
    assign step     = busy_reg && !done;

    assign push_valid = push;
    assign push_data  = {err, n_reg, digits_reg};

    always_comb begin
        busy_next = busy_reg;
        rest_next = rest_reg;
        n_next    = n_reg;
        k_next    = k_reg;
        if (accept) begin
            busy_next = 1'b1;
            rest_next = s_value;
            n_next    = digit_count;
            k_next    = '0;
        end else if (finish) begin
            busy_next = 1'b0;
        end else if (step) begin
            rest_next = quot;
            k_next    = k_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        rest_reg <= rest_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        // least significant digit lands at index 0
        if (step) begin
            digits_reg[k_reg[IDX_W-1:0]] <= rem_digit;
        end
    end

endmodule

[hdl/bcdd_back.sv]
// Back end: walks the queued digits most significant first into the output register.
module bcdd_back #(
    parameter int MAX_DIGITS = bcdd_pkg::MAX_DIGITS_DEFAULT
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        head_valid,
    input  logic [MAX_DIGITS*bcdd_pkg::DIGIT_W+bcdd_pkg::CNT_W:0] head_data,
    output logic                                        pop,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic [bcdd_pkg::DIGIT_W-1:0]                m_bcd_lines,
    output logic [bcdd_pkg::POS_W-1:0]                  m_digit_position,
    output logic                                        m_last_digit,
    output logic                                        m_overflow_error
);

    localparam int IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int DIGS_W = MAX_DIGITS * bcdd_pkg::DIGIT_W;

    logic [bcdd_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                         m_valid_reg, m_valid_next;
    logic [bcdd_pkg::DIGIT_W-1:0] bcd_reg, bcd_next;
    logic [bcdd_pkg::POS_W-1:0]   dpos_reg, dpos_next;
    logic                         last_reg, last_next;
    logic                         oerr_reg, oerr_next;

    logic                                   h_err;
    logic [bcdd_pkg::CNT_W-1:0]             h_n;
    logic [MAX_DIGITS-1:0][bcdd_pkg::DIGIT_W-1:0] h_digits;
    logic [bcdd_pkg::CNT_W-1:0]             rd_idx;
    logic                                   load, is_last;

    assign h_err    = head_data[DIGS_W+bcdd_pkg::CNT_W];
    assign h_n      = head_data[DIGS_W +: bcdd_pkg::CNT_W];
    assign h_digits = head_data[DIGS_W-1:0];
    assign rd_idx   = h_n - 1'b1 - pos_reg;
    assign is_last  = h_err || (pos_reg == h_n - 1'b1);
    assign load     = head_valid && (!m_valid_reg || m_ready);
    assign pop      = load && is_last;

    always_comb begin
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        bcd_next     = bcd_reg;
        dpos_next    = dpos_reg;
        last_next    = last_reg;
        oerr_next    = oerr_reg;
        if (load) begin
            m_valid_next = 1'b1;
            oerr_next    = h_err;
            last_next    = is_last;
            if (h_err) begin
                bcd_next  = '0;
                dpos_next = '0;
            end else begin
                bcd_next  = h_digits[rd_idx[IDX_W-1:0]];
                dpos_next = pos_reg;
            end
            pos_next = is_last ? '0 : pos_reg + 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bcd_reg  <= bcd_next;
        dpos_reg <= dpos_next;
        last_reg <= last_next;
        oerr_reg <= oerr_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_bcd_lines      = bcd_reg;
    assign m_digit_position = dpos_reg;
    assign m_last_digit     = last_reg;
    assign m_overflow_error = oerr_reg;

endmodule

[hdl/bcd_digit_display_driver.sv]
// Top level of the BCD digit display driver: config register, front, queue, back.
//
// Usage: write the digit count (1..MAX_DIGITS) on the cfg channel while idle;
// reset loads 3. Each beat on the s_ channel carries a 32-bit unsigned value.
// For each value the m_ channel returns one beat per digit, most significant
// first, with the BCD code, the digit-select index (0 = leftmost) and
// m_last_digit on the final beat. A value that does not fit, or a count above
// MAX_DIGITS, gives a single beat with m_overflow_error and m_last_digit set.
// A zero count with a zero value returns nothing.
// Timing: the front produces one digit per cycle with a reciprocal multiply
// and takes a new value only as it finishes the last one. The back emits one
// beat per cycle while m_ready is high, each from its output register.
// A two-entry queue between front and back, plus the output register, lets
// the front keep converting while m_ready is low; a stall backs up into
// s_ready only once the queue is full. Reset empties queue and output.
module bcd_digit_display_driver #(
    parameter int MAX_DIGITS = bcdd_pkg::MAX_DIGITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bcdd_pkg::CNT_W-1:0]    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bcdd_pkg::VALUE_W-1:0]  s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bcdd_pkg::DIGIT_W-1:0]  m_bcd_lines,
    output logic [bcdd_pkg::POS_W-1:0]    m_digit_position,
    output logic                          m_last_digit,
    output logic                          m_overflow_error
);

    localparam int ENTRY_W = MAX_DIGITS * bcdd_pkg::DIGIT_W + bcdd_pkg::CNT_W + 1;

    logic [bcdd_pkg::CNT_W-1:0] digit_count_reg, digit_count_next;
    logic                       push_valid, push_ready, head_valid, pop;
    logic [ENTRY_W-1:0]         push_data, head_data;

    assign cfg_ready        = 1'b1;
    assign digit_count_next = (cfg_valid && cfg_ready) ? cfg_data : digit_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg <= bcdd_pkg::DIGIT_COUNT_RESET;
        end else begin
            digit_count_reg <= digit_count_next;
        end
    end

    bcdd_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .digit_count (digit_count_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    bcdd_queue #(.WIDTH(ENTRY_W)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .head_valid (head_valid),
        .pop        (pop),
        .head_data  (head_data)
    );

    bcdd_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (head_valid),
        .head_data        (head_data),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_bcd_lines      (m_bcd_lines),
        .m_digit_position (m_digit_position),
        .m_last_digit     (m_last_digit),
        .m_overflow_error (m_overflow_error)
    );

    // error beat stands alone and carries zero fields
    a_err_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow_error |-> m_last_digit && m_bcd_lines == '0
                                        && m_digit_position == '0)
        else $error("overflow beat malformed");

    // a digit beat holds a decimal digit
    a_bcd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_overflow_error |-> m_bcd_lines <= 4'd9)
        else $error("digit beat out of decimal range");

    // digit position never reaches the configured count
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_overflow_error |-> m_digit_position < digit_count_reg)
        else $error("digit position beyond count");

    // the last digit beat sits at the rightmost position
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_overflow_error && m_last_digit
            |-> m_digit_position == digit_count_reg - 1'b1)
        else $error("last marker on wrong position");

endmodule

[tb/bcd_digit_display_driver_tb.sv]
// Self-checking testbench for the BCD digit display driver.
module bcd_digit_display_driver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 29;
    localparam int NUM_PHASES     = 12;
    localparam logic [bcdd_pkg::CNT_W-1:0] PHASE_COUNTS [NUM_PHASES] =
        '{4'd4, 4'd1, 4'd10, 4'd9, 4'd0, 4'd2, 4'd13, 4'd7, 4'd5, 4'd10, 4'd6, 4'd8};

    typedef struct packed {
        logic [bcdd_pkg::DIGIT_W-1:0] bcd;
        logic [bcdd_pkg::POS_W-1:0]   pos;
        logic                         last;
        logic                         err;
    } digit_beat_t;

    class digit_scoreboard;
        digit_beat_t expected_beats[$];
        int          errors = 0;

        function int pending();
            return expected_beats.size();
        endfunction

        // Work out the digit beats one value produces under the given count.
        function void note_value(logic [bcdd_pkg::VALUE_W-1:0] v,
                                 logic [bcdd_pkg::CNT_W-1:0] n);
            logic [bcdd_pkg::VALUE_W-1:0] rest;
            logic [bcdd_pkg::DIGIT_W-1:0] digits [16];
            digit_beat_t                  beat;
            rest = v;
            if (n > bcdd_pkg::MAX_DIGITS_DEFAULT) begin
                expected_beats.push_back('{bcd: '0, pos: '0, last: 1'b1, err: 1'b1});
                return;
            end
            for (int i = 0; i < n; i++) begin
                digits[n - 1 - i] = bcdd_pkg::DIGIT_W'(rest % 10);
                rest = rest / 10;
            end
            if (rest != 0) begin
                expected_beats.push_back('{bcd: '0, pos: '0, last: 1'b1, err: 1'b1});
                return;
            end
            for (int i = 0; i < n; i++) begin
                beat.bcd  = digits[i];
                beat.pos  = bcdd_pkg::POS_W'(i);
                beat.last = (i + 1 == n);
                beat.err  = 1'b0;
                expected_beats.push_back(beat);
            end
        endfunction

        function void check_beat(digit_beat_t got);
            digit_beat_t want;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat bcd=%0d pos=%0d last=%0b err=%0b",
                         $time, got.bcd, got.pos, got.last, got.err);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            if (got.bcd !== want.bcd) begin
                $display("%0t: bcd_lines expected %0d got %0d", $time, want.bcd, got.bcd);
                errors++;
            end
            if (got.pos !== want.pos) begin
                $display("%0t: digit_position expected %0d got %0d",
                         $time, want.pos, got.pos);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last_digit expected %0b got %0b", $time, want.last, got.last);
                errors++;
            end
            if (got.err !== want.err) begin
                $display("%0t: overflow_error expected %0b got %0b",
                         $time, want.err, got.err);
                errors++;
            end
        endfunction
    endclass

    logic                               aclk             = 1'b0;
    logic                               aresetn          = 1'b0;
    logic                               cfg_valid        = 1'b0;
    logic                               cfg_ready;
    logic [bcdd_pkg::CNT_W-1:0]         cfg_data         = '0;
    logic                               s_valid          = 1'b0;
    logic                               s_ready;
    logic [bcdd_pkg::VALUE_W-1:0]       s_value          = '0;
    logic                               m_valid;
    logic                               m_ready          = 1'b0;
    logic [bcdd_pkg::DIGIT_W-1:0]       m_bcd_lines;
    logic [bcdd_pkg::POS_W-1:0]         m_digit_position;
    logic                               m_last_digit;
    logic                               m_overflow_error;

    digit_scoreboard                    sb = new();
    logic [bcdd_pkg::CNT_W-1:0]         disp_count   = bcdd_pkg::DIGIT_COUNT_RESET;
    int                                 tx_idle_pct  = 0;
    int                                 rx_stall_pct = 0;
    int                                 quiet_cycles = 0;

    bcd_digit_display_driver i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_bcd_lines      (m_bcd_lines),
        .m_digit_position (m_digit_position),
        .m_last_digit     (m_last_digit),
        .m_overflow_error (m_overflow_error)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_beat('{bcd: m_bcd_lines, pos: m_digit_position,
                            last: m_last_digit, err: m_overflow_error});
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[bcd_digit_display_driver] ERROR");
            $finish;
        end
    end

    task automatic send_value(input logic [bcdd_pkg::VALUE_W-1:0] v);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        sb.note_value(v, disp_count);
    endtask

    // Drain, let the block settle, then write the digit count.
    task automatic set_count(input logic [bcdd_pkg::CNT_W-1:0] c);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        disp_count  = c;
    endtask

    function automatic logic [bcdd_pkg::VALUE_W-1:0] rand_value(
        input logic [bcdd_pkg::CNT_W-1:0] n);
        longint unsigned limit;
        limit = 1;
        for (int i = 0; i < n; i++) limit = limit * 10;
        if (n == 0 || n >= 10) begin
            return ($urandom_range(3) == 0) ? '0 : bcdd_pkg::VALUE_W'($urandom);
        end
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return bcdd_pkg::VALUE_W'($urandom_range(int'(limit - 1), 0));
            6:                return bcdd_pkg::VALUE_W'(limit - $urandom_range(1, 0));
            default:          return bcdd_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset count of three: zero, widest fit, first overflow, all ones, 7 and 100
        send_value(32'd0);
        send_value(32'd999);
        send_value(32'd1000);
        send_value(32'hFFFF_FFFF);
        send_value(32'd7);
        send_value(32'd100);
        set_count(4'd10);
        send_value(32'hFFFF_FFFF);
        send_value(32'd0);
        send_value(32'd1234567890);
        send_value(32'd1000000000);
        set_count(4'd9);
        send_value(32'd999999999);
        send_value(32'd1000000000);
        set_count(4'd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'd0);
        // zero count: zero gives nothing, anything else overflows
        set_count(4'd0);
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd0);
        // counts above the display width always overflow
        set_count(4'd15);
        send_value(32'd0);
        send_value(32'd5);
        set_count(4'd11);
        send_value(32'd3);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_count(PHASE_COUNTS[ph]);
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 76; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 76; end
                default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
            endcase
            repeat (PHASE_ITEMS) send_value(rand_value(disp_count));
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[bcd_digit_display_driver] OK");
        end else begin
            $display("[bcd_digit_display_driver] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/bcdd_pkg.sv
hdl/bcdd_queue.sv
hdl/bcdd_front.sv
hdl/bcdd_back.sv
hdl/bcd_digit_display_driver.sv
tb/bcd_digit_display_driver_tb.sv
